FILE: design/vrt_pkg.sv
package vrt_pkg;

  localparam int CELL_SIZE_WIDTH     = 16;
  localparam int T_INT_BITS          = 16;
  localparam int COORD_WIDTH_DEF     = 24;
  localparam int T_FRACTION_BITS_DEF = 24;
  localparam int NUM_AXES            = 3;

  localparam logic [CELL_SIZE_WIDTH-1:0] CELL_SIZE_RESET = 16'd256;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_NORAY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    PH_START,
    PH_END,
    PH_TMAX,
    PH_TDELTA
  } phase_e;

endpackage

FILE: design/voxel_ray_traversal.sv
// Channel  Handshake                 Payload
// -------  ------------------------  ---------------------------------------------
// in       in_valid_i / in_stall_o   action_i, start_{x,y,z}_i, end_{x,y,z}_i
// out      out_valid_o / out_stall_i cell_{x,y,z}_o, final_cell_o, status_o
// config   cell_size_we_i            cell_size_i
//
// A step transaction is computed combinationally; its result lands in the output register.
// A load runs twelve divisions through one restoring divider, each one a SETUP
// state and then a DIV state that builds an NW-bit quotient (NW = max(COORD_WIDTH,
// 17 + T_FRACTION_BITS), 41 by default); no input is taken meanwhile.
// Reset is asynchronous and active low; it restores cell_size to 256 and drops the ray.
// A stalled output holds its result and blocks the next transaction.
module voxel_ray_traversal #(
  parameter int COORD_WIDTH     = vrt_pkg::COORD_WIDTH_DEF,
  parameter int T_FRACTION_BITS = vrt_pkg::T_FRACTION_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cell_size_we_i,
  input  logic [vrt_pkg::CELL_SIZE_WIDTH-1:0]  cell_size_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 action_i,
  input  logic signed [COORD_WIDTH-1:0]        start_x_i,
  input  logic signed [COORD_WIDTH-1:0]        start_y_i,
  input  logic signed [COORD_WIDTH-1:0]        start_z_i,
  input  logic signed [COORD_WIDTH-1:0]        end_x_i,
  input  logic signed [COORD_WIDTH-1:0]        end_y_i,
  input  logic signed [COORD_WIDTH-1:0]        end_z_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [COORD_WIDTH-1:0]        cell_x_o,
  output logic signed [COORD_WIDTH-1:0]        cell_y_o,
  output logic signed [COORD_WIDTH-1:0]        cell_z_o,
  output logic                                 final_cell_o,
  output logic                                 status_o
);
  import vrt_pkg::*;

  localparam int CW    = COORD_WIDTH;
  localparam int TF    = T_FRACTION_BITS;
  localparam int TW    = T_INT_BITS + TF;
  localparam int CSW   = CELL_SIZE_WIDTH;
  localparam int DW    = (CSW > CW + 1) ? CSW : CW + 1;
  localparam int NW    = (CW > CSW + 1 + TF) ? CW : CSW + 1 + TF;
  localparam int CNT_W = $clog2(NW);

  state_e             state_q, state_d;
  phase_e             ph_q, ph_d;
  logic [1:0]         ax_q, ax_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CSW-1:0]     cell_size_q, cell_size_d;

  logic [CW-1:0]      s_q [NUM_AXES];
  logic [CW-1:0]      s_d [NUM_AXES];
  logic [CW-1:0]      e_q [NUM_AXES];
  logic [CW-1:0]      e_d [NUM_AXES];
  logic [CW-1:0]      cur_q [NUM_AXES];
  logic [CW-1:0]      cur_d [NUM_AXES];
  logic [CW-1:0]      last_q [NUM_AXES];
  logic [CW-1:0]      last_d [NUM_AXES];
  logic [TW-1:0]      tnext_q [NUM_AXES];
  logic [TW-1:0]      tnext_d [NUM_AXES];
  logic [TW-1:0]      tstep_q [NUM_AXES];
  logic [TW-1:0]      tstep_d [NUM_AXES];
  logic [NUM_AXES-1:0] stepneg_q, stepneg_d;
  logic [NUM_AXES-1:0] adjmask_q, adjmask_d;
  logic               adjpend_q, adjpend_d;
  logic               active_q, active_d;
  logic [CSW-1:0]     rs_q, rs_d;

  logic [NW-1:0]      n_q, n_d;
  logic [DW-1:0]      den_q, den_d;
  logic [DW-1:0]      rem_q, rem_d;

  logic               out_valid_q, out_valid_d;
  logic [CW-1:0]      ocell_q [NUM_AXES];
  logic [CW-1:0]      ocell_d [NUM_AXES];
  logic               ofin_q, ofin_d;
  logic               ostat_q, ostat_d;

  logic               out_free;
  logic               in_acc;
  logic [CSW-1:0]     c_eff;
  logic [CW-1:0]      s_sel, e_sel;
  logic signed [CW:0] ray;
  logic [CW:0]        ray_abs;
  logic [CW-1:0]      s_abs, e_abs;
  logic [CSW:0]       tmax_num;
  logic [DW:0]        div_sh;
  logic [DW:0]        div_diff;
  logic               div_ge;
  logic [DW-1:0]      rem_nx;
  logic [NW-1:0]      quo_nx;
  logic [CW-1:0]      floor_q;
  logic [CSW-1:0]     floor_r;
  logic [TW-1:0]      quo_sat;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign c_eff      = (cell_size_q == '0) ? CSW'(1) : cell_size_q;

  assign s_sel   = s_q[ax_q];
  assign e_sel   = e_q[ax_q];
  assign ray     = $signed({e_sel[CW-1], e_sel}) - $signed({s_sel[CW-1], s_sel});
  assign ray_abs = ray[CW] ? (CW+1)'(-ray) : ray;
  assign s_abs   = s_sel[CW-1] ? CW'(-s_sel) : s_sel;
  assign e_abs   = e_sel[CW-1] ? CW'(-e_sel) : e_sel;

  always_comb begin
    if (!ray[CW]) begin
      if (!s_sel[CW-1]) begin
        tmax_num = (CSW+1)'(c_eff) - (CSW+1)'(rs_q);
      end else begin
        tmax_num = (rs_q != '0) ? (CSW+1)'(rs_q) : (CSW+1)'(c_eff);
      end
    end else begin
      if (!s_sel[CW-1]) begin
        tmax_num = (CSW+1)'(rs_q) + (CSW+1)'(c_eff);
      end else if (rs_q != '0) begin
        tmax_num = {c_eff, 1'b0} - (CSW+1)'(rs_q);
      end else begin
        tmax_num = (CSW+1)'(c_eff);
      end
    end
  end

  assign div_sh   = {rem_q, n_q[NW-1]};
  assign div_diff = div_sh - {1'b0, den_q};
  assign div_ge   = div_sh >= {1'b0, den_q};
  assign rem_nx   = div_ge ? div_diff[DW-1:0] : div_sh[DW-1:0];
  assign quo_nx   = {n_q[NW-2:0], div_ge};
  assign floor_r  = rem_nx[CSW-1:0];
  assign quo_sat  = (|quo_nx[NW-1:TW]) ? '1 : quo_nx[TW-1:0];

  always_comb begin
    if (ph_q == PH_END ? e_sel[CW-1] : s_sel[CW-1]) begin
      floor_q = ~quo_nx[CW-1:0] + CW'(floor_r == '0);
    end else begin
      floor_q = quo_nx[CW-1:0];
    end
  end

  always_comb begin
    logic [1:0]          sel_ax;
    logic [CW-1:0]       nc [NUM_AXES];
    logic [TW:0]         tsum;
    logic                fin;
    logic [NUM_AXES-1:0] mask;

    state_d     = state_q;
    ph_d        = ph_q;
    ax_d        = ax_q;
    cnt_d       = cnt_q;
    cell_size_d = cell_size_we_i ? cell_size_i : cell_size_q;
    s_d         = s_q;
    e_d         = e_q;
    cur_d       = cur_q;
    last_d      = last_q;
    tnext_d     = tnext_q;
    tstep_d     = tstep_q;
    stepneg_d   = stepneg_q;
    adjmask_d   = adjmask_q;
    adjpend_d   = adjpend_q;
    active_d    = active_q;
    rs_d        = rs_q;
    n_d         = n_q;
    den_d       = den_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q && out_stall_i;
    ocell_d     = ocell_q;
    ofin_d      = ofin_q;
    ostat_d     = ostat_q;
    nc          = cur_q;
    sel_ax      = 2'd0;
    tsum        = '0;
    fin         = 1'b0;
    mask        = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (action_i == ACT_LOAD) begin
            s_d[0]  = start_x_i;
            s_d[1]  = start_y_i;
            s_d[2]  = start_z_i;
            e_d[0]  = end_x_i;
            e_d[1]  = end_y_i;
            e_d[2]  = end_z_i;
            ax_d    = 2'd0;
            ph_d    = PH_START;
            state_d = ST_SETUP;
          end else if (!active_q) begin
            out_valid_d = 1'b1;
            for (int i = 0; i < NUM_AXES; i++) begin
              ocell_d[i] = '0;
            end
            ofin_d  = 1'b0;
            ostat_d = STATUS_NORAY;
          end else begin
            if (adjpend_q) begin
              for (int i = 0; i < NUM_AXES; i++) begin
                nc[i] = cur_q[i] - CW'(adjmask_q[i]);
              end
              adjpend_d = 1'b0;
            end else begin
              if (tnext_q[0] < tnext_q[1]) begin
                sel_ax = (tnext_q[0] < tnext_q[2]) ? 2'd0 : 2'd2;
              end else begin
                sel_ax = (tnext_q[1] < tnext_q[2]) ? 2'd1 : 2'd2;
              end
              nc[sel_ax] = stepneg_q[sel_ax] ? cur_q[sel_ax] - CW'(1)
                                             : cur_q[sel_ax] + CW'(1);
              tsum = {1'b0, tnext_q[sel_ax]} + {1'b0, tstep_q[sel_ax]};
              tnext_d[sel_ax] = tsum[TW] ? '1 : tsum[TW-1:0];
            end
            fin = (nc[0] == last_q[0]) && (nc[1] == last_q[1]) && (nc[2] == last_q[2]);
            if (fin) begin
              active_d = 1'b0;
            end
            cur_d       = nc;
            out_valid_d = 1'b1;
            ocell_d     = nc;
            ofin_d      = fin;
            ostat_d     = STATUS_OK;
          end
        end
      end
      ST_SETUP: begin
        rem_d = '0;
        cnt_d = '0;
        unique case (ph_q)
          PH_START: begin
            n_d   = NW'(s_abs);
            den_d = DW'(c_eff);
          end
          PH_END: begin
            n_d   = NW'(e_abs);
            den_d = DW'(c_eff);
          end
          PH_TMAX: begin
            n_d   = NW'({tmax_num, {TF{1'b0}}});
            den_d = DW'(ray_abs);
          end
          default: begin
            n_d   = NW'({1'b0, c_eff, {TF{1'b0}}});
            den_d = DW'(ray_abs);
          end
        endcase
        state_d = ST_DIV;
      end
      ST_DIV: begin
        n_d   = quo_nx;
        rem_d = rem_nx;
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(NW - 1)) begin
          state_d = ST_SETUP;
          unique case (ph_q)
            PH_START: begin
              cur_d[ax_q] = floor_q;
              rs_d        = floor_r;
              ph_d        = PH_END;
            end
            PH_END: begin
              last_d[ax_q] = floor_q;
              ph_d         = PH_TMAX;
            end
            PH_TMAX: begin
              tnext_d[ax_q] = (ray == '0) ? '1 : quo_sat;
              ph_d          = PH_TDELTA;
            end
            default: begin
              tstep_d[ax_q]   = (ray == '0) ? '1 : quo_sat;
              stepneg_d[ax_q] = ray[CW];
              ph_d            = PH_START;
              if (ax_q == 2'(NUM_AXES - 1)) begin
                state_d = ST_DONE;
              end else begin
                ax_d = ax_q + 2'd1;
              end
            end
          endcase
        end
      end
      ST_DONE: begin
        if (out_free) begin
          for (int i = 0; i < NUM_AXES; i++) begin
            mask[i] = stepneg_q[i] && (cur_q[i] != last_q[i]);
          end
          fin = (cur_q[0] == last_q[0]) && (cur_q[1] == last_q[1]) &&
                (cur_q[2] == last_q[2]);
          adjmask_d   = mask;
          adjpend_d   = mask != '0;
          active_d    = !fin;
          out_valid_d = 1'b1;
          ocell_d     = cur_q;
          ofin_d      = fin;
          ostat_d     = STATUS_OK;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ph_q        <= PH_START;
      ax_q        <= 2'd0;
      cnt_q       <= '0;
      cell_size_q <= CELL_SIZE_RESET;
      for (int i = 0; i < NUM_AXES; i++) begin
        cur_q[i]   <= '0;
        last_q[i]  <= '0;
        tnext_q[i] <= '0;
        tstep_q[i] <= '0;
      end
      stepneg_q   <= '0;
      adjmask_q   <= '0;
      adjpend_q   <= 1'b0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ph_q        <= ph_d;
      ax_q        <= ax_d;
      cnt_q       <= cnt_d;
      cell_size_q <= cell_size_d;
      cur_q       <= cur_d;
      last_q      <= last_d;
      tnext_q     <= tnext_d;
      tstep_q     <= tstep_d;
      stepneg_q   <= stepneg_d;
      adjmask_q   <= adjmask_d;
      adjpend_q   <= adjpend_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q     <= s_d;
    e_q     <= e_d;
    rs_q    <= rs_d;
    n_q     <= n_d;
    den_q   <= den_d;
    rem_q   <= rem_d;
    ocell_q <= ocell_d;
    ofin_q  <= ofin_d;
    ostat_q <= ostat_d;
  end

  assign out_valid_o  = out_valid_q;
  assign cell_x_o     = ocell_q[0];
  assign cell_y_o     = ocell_q[1];
  assign cell_z_o     = ocell_q[2];
  assign final_cell_o = ofin_q;
  assign status_o     = ostat_q;

  a_adj_needs_ray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adjpend_q |-> active_q)
    else $error("adjustment pending without an active ray");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (cnt_q <= CNT_W'(NW - 1)))
    else $error("divider count out of range");

  a_done_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && !out_free) |=> (state_q == ST_DONE))
    else $error("load result dropped while output stalled");

  a_noray_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == STATUS_NORAY) |-> (!final_cell_o && cell_x_o == '0))
    else $error("error result carries cell data");

endmodule
